FILE: sv/i2cmt_pkg.sv
// Shared types and constants for the multi-target I2C register file.
// Holds sizing constants, mode and status codes, and transaction structs.
// No dependencies.
package i2cmt_pkg;

    // Sizing of the target bus.
    localparam int TARGET_COUNT = 8;
    localparam int MAX_BURST    = 32;
    localparam int REG_W        = 8;
    localparam int REG_COUNT    = 1 << REG_W;
    localparam int TGT_W        = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
    localparam int ADDR_W       = TGT_W + REG_W;
    localparam int MEM_DEPTH    = TARGET_COUNT * REG_COUNT;

    // Limits in the widths of the fields they are compared with.
    localparam logic [7:0] TARGET_LIMIT = 8'(TARGET_COUNT);
    localparam logic [6:0] MAX_LEN      = 7'(MAX_BURST);

    // Transaction modes.
    localparam logic [1:0] MODE_REG   = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_PROBE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_NACK  = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] target;
        logic [7:0] start_reg;
        logic [6:0] length;
        logic [5:0] byte_index;
        logic [7:0] write_byte;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  read_byte;
        logic        last;
        logic [31:0] transactions;
        logic [31:0] nacks;
    } t_result;

    // Request to the register memory.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [REG_W-1:0]  wdata;
    } t_mem_req;

endpackage

FILE: sv/i2c_multi_target_register_file.sv
// Top level of the multi-target I2C register file.
// Connects the sequencer, the register memory and the result queue; uses i2cmt_pkg.
//
// The block holds 256 byte registers for each of TARGET_COUNT targets in one
// single-port memory with a registered read. Write, probe and error
// transactions give one result and can be accepted every cycle while the result
// queue has room. A read burst of N bytes occupies the block until its last byte
// is handed out; the memory port delivers one byte per cycle while the queue has
// room. Registering a target zeroes its 256 registers one per cycle through the
// same write port, and no input is taken meanwhile. There is no clearing pass
// after reset; a target's registers are defined once it has been registered.
module i2c_multi_target_register_file (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  i2cmt_pkg::t_item    i_item,
    output logic                o_stall,
    output logic                o_valid,
    output i2cmt_pkg::t_result  o_result,
    input  logic                i_stall
);
    import i2cmt_pkg::*;

    t_mem_req         mem_req;
    logic [REG_W-1:0] mem_rdata;
    logic             q_full;
    logic             q_push;
    t_result          q_push_data;

    // Transaction sequencer.
    i2cmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata)
    );

    // Register storage of all targets.
    i2cmt_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Result queue toward the output channel.
    i2cmt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall)
    );

endmodule

FILE: sv/i2cmt_mem.sv
// Register memory of all targets: one synchronous port with a registered read.
// Depends on i2cmt_pkg for sizing and the request struct.
module i2cmt_mem (
    input  logic                          i_clk,
    input  i2cmt_pkg::t_mem_req           i_req,
    output logic [i2cmt_pkg::REG_W-1:0]   o_rdata
);
    import i2cmt_pkg::*;

    logic [REG_W-1:0] mem [MEM_DEPTH];
    logic [REG_W-1:0] r_rdata;

    // Write and registered read; a target's rows are addressed as {target, register}.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/i2cmt_outq.sv
// Two-entry result queue that separates the sequencer from the output channel.
// Depends on i2cmt_pkg for the result struct.
module i2cmt_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cmt_pkg::t_result  i_push_data,
    output logic                o_full,
    output logic                o_valid,
    output i2cmt_pkg::t_result  o_result,
    input  logic                i_stall
);
    import i2cmt_pkg::*;

    t_result    r_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_result = r_q[0];

    // Occupancy count.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Entry storage; the head is always entry zero. A push that lands at the
    // head takes precedence over the shift of the second entry.
    always_ff @(posedge i_clk) begin
        if (i_push && (n_cnt == 2'd1)) begin
            r_q[0] <= i_push_data;
        end else if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && (n_cnt == 2'd2)) begin
            r_q[1] <= i_push_data;
        end
    end

endmodule

FILE: sv/i2cmt_ctrl.sv
// Transaction sequencer: decodes items, keeps present bits and counters,
// and drives the register memory for writes, read bursts and target clears.
// Depends on i2cmt_pkg.
module i2cmt_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  i2cmt_pkg::t_item                  i_item,
    output logic                              o_stall,
    input  logic                              i_full,
    output logic                              o_push,
    output i2cmt_pkg::t_result                o_push_data,
    output i2cmt_pkg::t_mem_req               o_mem_req,
    input  logic [i2cmt_pkg::REG_W-1:0]       i_rdata
);
    import i2cmt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLEAR = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [TARGET_COUNT-1:0] r_present, n_present;
    logic [31:0]             r_txn, n_txn;
    logic [31:0]             r_nack, n_nack;
    logic [TGT_W-1:0]        r_tgt, n_tgt;
    logic [REG_W-1:0]        r_addr, n_addr;
    logic [6:0]              r_left, n_left;

    logic             accept;
    logic             tgt_ok;
    logic [TGT_W-1:0] tgt_idx;
    logic             present;
    logic             len_ok;
    logic             idx_ok;
    logic             idx_last;
    logic [REG_W-1:0] wr_reg;

    // Handshake: items are taken only between transactions with queue room.
    assign o_stall = (r_state != S_IDLE) || i_full;
    assign accept  = i_valid && !o_stall;

    // Field checks of the incoming item.
    assign tgt_ok   = (i_item.target < TARGET_LIMIT);
    assign tgt_idx  = i_item.target[TGT_W-1:0];
    assign present  = tgt_ok && r_present[tgt_idx];
    assign len_ok   = (i_item.length != 7'd0) && (i_item.length <= MAX_LEN);
    assign idx_ok   = ({1'b0, i_item.byte_index} < i_item.length);
    assign idx_last = ({1'b0, i_item.byte_index} == (i_item.length - 7'd1));
    assign wr_reg   = i_item.start_reg + {2'b00, i_item.byte_index};

    // Next-state, memory request and result generation.
    always_comb begin
        n_state   = r_state;
        n_present = r_present;
        n_txn     = r_txn;
        n_nack    = r_nack;
        n_tgt     = r_tgt;
        n_addr    = r_addr;
        n_left    = r_left;
        o_push    = 1'b0;
        o_mem_req = '0;
        o_push_data.status    = ST_OK;
        o_push_data.read_byte = '0;
        o_push_data.last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_push = 1'b1;
                    if (!tgt_ok) begin
                        o_push_data.status = ST_PARAM;
                    end else begin
                        unique case (i_item.mode)
                            MODE_REG: begin
                                n_present[tgt_idx] = 1'b1;
                                n_tgt   = tgt_idx;
                                n_addr  = '0;
                                n_state = S_CLEAR;
                            end
                            MODE_PROBE: begin
                                o_push_data.status = present ? ST_OK : ST_NACK;
                            end
                            default: begin
                                // Write byte or read burst.
                                priority if (!present) begin
                                    o_push_data.status = ST_NACK;
                                    if ((i_item.mode == MODE_READ) ||
                                        (i_item.byte_index == 6'd0)) begin
                                        n_nack = r_nack + 32'd1;
                                    end
                                end else if (!len_ok) begin
                                    o_push_data.status = ST_PARAM;
                                end else if (i_item.mode == MODE_WRITE) begin
                                    if (!idx_ok) begin
                                        o_push_data.status = ST_PARAM;
                                    end else begin
                                        o_mem_req.we    = 1'b1;
                                        o_mem_req.addr  = {tgt_idx, wr_reg};
                                        o_mem_req.wdata = i_item.write_byte;
                                        if (idx_last) begin
                                            n_txn = r_txn + 32'd1;
                                        end
                                    end
                                end else begin
                                    // Read burst: first byte is fetched now.
                                    o_push         = 1'b0;
                                    n_txn          = r_txn + 32'd1;
                                    o_mem_req.re   = 1'b1;
                                    o_mem_req.addr = {tgt_idx, i_item.start_reg};
                                    n_tgt          = tgt_idx;
                                    n_addr         = i_item.start_reg + 8'd1;
                                    n_left         = i_item.length;
                                    n_state        = S_READ;
                                end
                            end
                        endcase
                    end
                end
            end
            S_CLEAR: begin
                // Zero one register of the newly registered target per cycle.
                o_mem_req.we    = 1'b1;
                o_mem_req.addr  = {r_tgt, r_addr};
                o_mem_req.wdata = '0;
                n_addr = r_addr + 8'd1;
                if (r_addr == 8'hFF) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                // Hand out the fetched byte and fetch the next one.
                if (!i_full) begin
                    o_push = 1'b1;
                    o_push_data.read_byte = i_rdata;
                    o_push_data.last      = (r_left == 7'd1);
                    n_left = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem_req.re   = 1'b1;
                        o_mem_req.addr = {r_tgt, r_addr};
                        n_addr = r_addr + 8'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_push_data.transactions = n_txn;
        o_push_data.nacks        = n_nack;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_txn     <= '0;
            r_nack    <= '0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_txn     <= n_txn;
            r_nack    <= n_nack;
        end
    end

    // Burst and clear context.
    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_addr <= n_addr;
        r_left <= n_left;
    end

`ifndef SYNTHESIS
    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != 7'd0))
        else $error("read burst active with no bytes left");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("result pushed into a full queue");

    a_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_mem_req.we && !o_mem_req.re))
        else $error("clear sweep cycle without a memory write");

    a_nack_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nack != $past(r_nack)) |-> (r_nack == $past(r_nack) + 32'd1))
        else $error("NACK counter moved by more than one");
`endif

endmodule
